@@ design/gf2n_multiply_and_inverse_unit_macros.svh @@
// Assertion macros for the GF(2^n) arithmetic unit.
`ifndef GF2N_MULTIPLY_AND_INVERSE_UNIT_MACROS_SVH
`define GF2N_MULTIPLY_AND_INVERSE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define GMI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gmi assertion failed");
`define GMI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gmi assertion failed");
`else
`define GMI_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GMI_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ design/gmi_pkg.sv @@
`default_nettype none
package gmi_pkg;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [62:0] result;
    logic        bad_modulus;
  } rsp_t;

  typedef enum logic [1:0] {
    FUNC_CLMUL = 2'd0,
    FUNC_RMUL  = 2'd1,
    FUNC_INV   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_DIV,
    ST_ROT,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic load_inv;
    logic align;
    logic div;
    logic rot;
    logic mul;
    logic mul_reduce;
    logic out_load;
    logic out_zero;
    logic out_from_u;
    logic out_bad;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic d_zero;
    logic d_top;
    logic s_zero;
    logic mul_last;
  } sts_t;

  localparam int          MOD_W         = 33;
  localparam logic [32:0] MODULUS_RESET = 33'h11B;
  localparam int          CFG_AW        = 3;
  localparam int          CFG_DW        = 64;
  localparam logic [2:0]  ADDR_MODULUS  = 3'd0;

endpackage
`default_nettype wire

@@ design/gmi_ctrl.sv @@
`default_nettype none
module gmi_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  input  wire logic [1:0]    req_func,
  output logic               req_stall,
  input  wire logic          rsp_stall,
  output logic               rsp_valid,
  input  wire gmi_pkg::sts_t sts,
  output gmi_pkg::cmd_t      cmd
);

  gmi_pkg::state_t state;
  gmi_pkg::state_t state_next;
  logic [1:0]      op;
  logic            bad;
  logic            out_valid;
  logic            accept;
  logic            out_free;

  assign req_stall = (state != gmi_pkg::ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !out_valid || !rsp_stall;
  assign rsp_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gmi_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !rsp_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= req_func;
      bad <= sts.bad;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gmi_pkg::ST_IDLE: begin
        if (accept) begin
          if (sts.bad || !(req_func inside {gmi_pkg::FUNC_CLMUL, gmi_pkg::FUNC_RMUL,
                                            gmi_pkg::FUNC_INV})) begin
            state_next = gmi_pkg::ST_DONE;
          end else if (req_func == gmi_pkg::FUNC_CLMUL) begin
            state_next = gmi_pkg::ST_MUL;
          end else begin
            state_next = gmi_pkg::ST_ALIGN;
          end
        end
      end
      gmi_pkg::ST_ALIGN: begin
        if (sts.d_zero) begin
          state_next = gmi_pkg::ST_DONE;
        end else if (sts.d_top) begin
          state_next = gmi_pkg::ST_DIV;
        end
      end
      gmi_pkg::ST_DIV: begin
        if (sts.s_zero) begin
          state_next = (op == gmi_pkg::FUNC_RMUL) ? gmi_pkg::ST_MUL : gmi_pkg::ST_ROT;
        end
      end
      gmi_pkg::ST_ROT: begin
        state_next = gmi_pkg::ST_ALIGN;
      end
      gmi_pkg::ST_MUL: begin
        if (sts.mul_last) begin
          state_next = gmi_pkg::ST_DONE;
        end
      end
      gmi_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = gmi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gmi_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.load_inv   = (req_func == gmi_pkg::FUNC_INV);
    cmd.mul_reduce = (op == gmi_pkg::FUNC_RMUL);
    cmd.out_zero   = bad || !(op inside {gmi_pkg::FUNC_CLMUL, gmi_pkg::FUNC_RMUL,
                                         gmi_pkg::FUNC_INV});
    cmd.out_from_u = (op == gmi_pkg::FUNC_INV);
    cmd.out_bad    = bad;
    case (state)
      gmi_pkg::ST_IDLE:  cmd.load     = accept;
      gmi_pkg::ST_ALIGN: cmd.align    = !sts.d_zero;
      gmi_pkg::ST_DIV:   cmd.div      = 1'b1;
      gmi_pkg::ST_ROT:   cmd.rot      = 1'b1;
      gmi_pkg::ST_MUL:   cmd.mul      = 1'b1;
      gmi_pkg::ST_DONE:  cmd.out_load = out_free;
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ design/gmi_dpath.sv @@
`default_nettype none
module gmi_dpath #(
  parameter int MAX_DEGREE = 32
) (
  input  wire logic                       clk,
  input  wire gmi_pkg::cmd_t              cmd,
  input  wire logic [gmi_pkg::MOD_W-1:0]  modulus,
  input  wire gmi_pkg::req_t              req,
  output gmi_pkg::sts_t                   sts,
  output gmi_pkg::rsp_t                   rsp
);

  localparam int W  = MAX_DEGREE + 1;
  localparam int SW = $clog2(W);
  localparam int PW = 2 * MAX_DEGREE - 1;

  logic [W-1:0]          f;
  logic [W-1:0]          aw;
  logic [W-1:0]          x;
  logic [W-1:0]          d;
  logic [W-1:0]          u;
  logic [W-1:0]          v;
  logic [W-1:0]          t;
  logic [MAX_DEGREE-1:0] b;
  logic [PW-1:0]         acc;
  logic [SW-1:0]         s;
  logic [SW-1:0]         p;
  logic [SW-1:0]         n;
  logic [W-1:0]          pw;
  logic [PW-1:0]         acc_next;

  assign f  = modulus[W-1:0];
  assign aw = W'(req.operand_a[MAX_DEGREE-1:0]);

  assign sts.bad      = (f[W-1:1] == '0);
  assign sts.d_zero   = (d == '0);
  assign sts.d_top    = d[W-1];
  assign sts.s_zero   = (s == '0);
  assign sts.mul_last = (s == SW'(MAX_DEGREE - 1));

  // shift-and-add product, reduced one degree a step when asked
  always_comb begin
    pw = {acc[W-2:0], 1'b0};
    if (pw[n]) begin
      pw = pw ^ f;
    end
    if (b[MAX_DEGREE-1]) begin
      pw = pw ^ x;
    end
    if (cmd.mul_reduce) begin
      acc_next = PW'(pw);
    end else begin
      acc_next = {acc[PW-2:0], 1'b0} ^ (b[MAX_DEGREE-1] ? PW'(x) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s   <= '0;
      b   <= req.operand_b[MAX_DEGREE-1:0];
      acc <= '0;
      u   <= '0;
      t   <= '0;
      if (cmd.load_inv) begin
        x <= f;
        d <= aw;
        v <= W'(1);
      end else begin
        x <= aw;
        d <= f;
        v <= '0;
      end
    end else if (cmd.align) begin
      if (!d[W-1]) begin
        d <= {d[W-2:0], 1'b0};
        s <= s + 1'b1;
      end else begin
        p <= SW'(W - 1);
        n <= SW'(W - 1) - s;
      end
    end else if (cmd.div) begin
      // quotient bits arrive top first, so q * v builds up Horner style
      t <= {t[W-2:0], 1'b0} ^ (x[p] ? v : '0);
      if (x[p]) begin
        x <= x ^ d;
      end
      if (s != '0) begin
        d <= {1'b0, d[W-1:1]};
        p <= p - 1'b1;
        s <= s - 1'b1;
      end
    end else if (cmd.rot) begin
      x <= d;
      d <= x;
      u <= v;
      v <= u ^ t;
      t <= '0;
    end else if (cmd.mul) begin
      acc <= acc_next;
      b   <= {b[MAX_DEGREE-2:0], 1'b0};
      s   <= s + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.bad_modulus <= cmd.out_bad;
      if (cmd.out_zero) begin
        rsp.result <= '0;
      end else if (cmd.out_from_u) begin
        rsp.result <= 63'(u);
      end else begin
        rsp.result <= 63'(acc);
      end
    end
  end

endmodule
`default_nettype wire

@@ design/gf2n_multiply_and_inverse_unit.sv @@
// GF(2^n) multiply and inverse unit.
// Request channel (req_valid/req_stall/req): func, operand_a, operand_b. A request
// is taken when req_valid is high and req_stall low; one request is worked at a time.
// Response channel (rsp_valid/rsp_stall/rsp): result and bad_modulus, one per request.
// The response sits in an output register, so a new request is taken while it waits.
// Modulus register at byte address 0 of the APB port, 64-bit data, reset to 0x11B.
// Sequence from the accepting edge to rsp_valid:
//   plain multiply: one operand bit a cycle through the shift-add unit.
//   reduced multiply: operand_a is first reduced by the modulus, then multiplied as above.
//   inverse: repeated Euclid divisions, each done by the serial align/divide loop
//   and followed by a swap of the remainder and coefficient pairs.
//   bad modulus or unused code: straight to the response; zero operand for inverse: ends at align.
// Reset clears the controller and drops any response; the modulus returns to 0x11B.
// A stalled response holds; the next finished request then waits inside, with
// further requests stalled, until the held response is taken.
`default_nettype none
`include "gf2n_multiply_and_inverse_unit_macros.svh"
module gf2n_multiply_and_inverse_unit #(
  parameter int MAX_DEGREE = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  wire gmi_pkg::req_t               req,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output gmi_pkg::rsp_t                    rsp,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gmi_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [gmi_pkg::CFG_DW-1:0]  pwdata,
  output logic [gmi_pkg::CFG_DW-1:0]       prdata,
  output logic                             pready
);

  logic [gmi_pkg::MOD_W-1:0] modulus;
  gmi_pkg::cmd_t             cmd;
  gmi_pkg::sts_t             sts;

  assign pready = 1'b1;
  assign prdata = (paddr == gmi_pkg::ADDR_MODULUS) ? gmi_pkg::CFG_DW'(modulus) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= gmi_pkg::MODULUS_RESET;
    end else if (psel && penable && pwrite && pready && paddr == gmi_pkg::ADDR_MODULUS) begin
      modulus <= pwdata[gmi_pkg::MOD_W-1:0];
    end
  end

  gmi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_func  (req.func),
    .req_stall (req_stall),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  gmi_dpath #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dpath (
    .clk     (clk),
    .cmd     (cmd),
    .modulus (modulus),
    .req     (req),
    .sts     (sts),
    .rsp     (rsp)
  );

  `GMI_ASSERT_NXT(a_busy_after_req, clk, rst, req_valid && !req_stall, req_stall)
  `GMI_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.out_load, !rsp_valid || !rsp_stall)
  `GMI_ASSERT_IMP(a_div_nonzero, clk, rst, cmd.div, !sts.d_zero)
  `GMI_ASSERT_IMP(a_bad_zero, clk, rst, rsp_valid && rsp.bad_modulus, rsp.result == '0)

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 25000;
  localparam int HOLD_CYCLES = 350;

  typedef struct {
    logic [32:0] poly;
    logic [1:0]  func;
    logic [31:0] a;
    logic [31:0] b;
    bit          typed;
    logic [62:0] res;
    logic        bad;
  } dir_row_t;

  typedef struct {
    logic [32:0] poly;
    bit          rnd;
    int          count;
    int          mode;
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  gmi_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  gmi_pkg::rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [gmi_pkg::CFG_AW-1:0] paddr = '0;
  logic [gmi_pkg::CFG_DW-1:0] pwdata = '0;
  logic [gmi_pkg::CFG_DW-1:0] prdata;
  logic pready;

  logic [32:0] field_poly = gmi_pkg::MODULUS_RESET;
  gmi_pkg::rsp_t awaited [$];
  int mismatches = 0;
  int accepted_reqs = 0;
  int send_idle_pct = 22;
  int rsp_idle_pct = 64;
  int hold_left = 0;
  int hold_next = 0;
  int quiet_cycles = 0;

  logic [1:0] func_codes [3] = '{gmi_pkg::FUNC_CLMUL, gmi_pkg::FUNC_RMUL, gmi_pkg::FUNC_INV};

  dir_row_t directed_rows [25] = '{
    '{33'h11B, gmi_pkg::FUNC_CLMUL, 32'h0, 32'hFFFF_FFFF, 1'b1, 63'h0, 1'b0},
    '{33'h11B, gmi_pkg::FUNC_CLMUL, 32'h1, 32'hFFFF_FFFF, 1'b1, 63'hFFFF_FFFF, 1'b0},
    '{33'h11B, gmi_pkg::FUNC_CLMUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 63'h0, 1'b0},
    '{33'h11B, gmi_pkg::FUNC_CLMUL, 32'h8000_0000, 32'h8000_0000, 1'b1,
      63'h4000_0000_0000_0000, 1'b0},
    '{33'h11B, gmi_pkg::FUNC_RMUL, 32'h2, 32'h87, 1'b0, 63'h0, 1'b0},
    '{33'h11B, gmi_pkg::FUNC_RMUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 63'h0, 1'b0},
    '{33'h11B, gmi_pkg::FUNC_RMUL, 32'h0, 32'h55, 1'b1, 63'h0, 1'b0},
    '{33'h11B, gmi_pkg::FUNC_INV, 32'h0, 32'h1234, 1'b1, 63'h0, 1'b0},
    '{33'h11B, gmi_pkg::FUNC_INV, 32'h1, 32'h0, 1'b1, 63'h1, 1'b0},
    '{33'h11B, gmi_pkg::FUNC_INV, 32'h53, 32'hFFFF_FFFF, 1'b0, 63'h0, 1'b0},
    '{33'h11B, gmi_pkg::FUNC_INV, 32'h11B, 32'h0, 1'b1, 63'h1, 1'b0},
    '{33'h11B, gmi_pkg::FUNC_INV, 32'h236, 32'h0, 1'b0, 63'h0, 1'b0},
    '{33'h11B, gmi_pkg::FUNC_INV, 32'hFFFF_FFFF, 32'h0, 1'b0, 63'h0, 1'b0},
    '{33'h11B, FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 63'h0, 1'b0},
    '{33'h0, gmi_pkg::FUNC_CLMUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 63'h0, 1'b1},
    '{33'h0, gmi_pkg::FUNC_INV, 32'h53, 32'h0, 1'b1, 63'h0, 1'b1},
    '{33'h0, FUNC_UNUSED, 32'h1, 32'h1, 1'b1, 63'h0, 1'b1},
    '{33'h1, gmi_pkg::FUNC_RMUL, 32'h5, 32'h7, 1'b1, 63'h0, 1'b1},
    '{33'h1, gmi_pkg::FUNC_INV, 32'h1, 32'h0, 1'b1, 63'h0, 1'b1},
    '{33'h1_FFFF_FFFF, gmi_pkg::FUNC_INV, 32'hFFFF_FFFF, 32'h0, 1'b0, 63'h0, 1'b0},
    '{33'h1_FFFF_FFFF, gmi_pkg::FUNC_RMUL, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 63'h0, 1'b0},
    '{33'h2, gmi_pkg::FUNC_INV, 32'h3, 32'h0, 1'b0, 63'h0, 1'b0},
    '{33'h2, gmi_pkg::FUNC_RMUL, 32'h3, 32'h3, 1'b0, 63'h0, 1'b0},
    '{33'h1_0000_008D, gmi_pkg::FUNC_INV, 32'h2, 32'h0, 1'b0, 63'h0, 1'b0},
    '{33'h1_0000_008D, gmi_pkg::FUNC_CLMUL, 32'h2, 32'h8000_0000, 1'b1, 63'h1_0000_0000, 1'b0}
  };

  // mode 0: sender 22 / receiver 64, mode 1: swapped, mode 2: no idling
  phase_t phases [12] = '{
    '{33'h11B, 1'b0, 120, 0},
    '{33'h1_0000_008D, 1'b0, 100, 0},
    '{33'h0, 1'b1, 110, 0},
    '{33'h13, 1'b0, 100, 0},
    '{33'h1_FFFF_FFFF, 1'b0, 100, 1},
    '{33'h0, 1'b0, 30, 1},
    '{33'h0, 1'b1, 110, 1},
    '{33'h3, 1'b0, 80, 1},
    '{33'h1, 1'b0, 30, 2},
    '{33'h2, 1'b0, 60, 2},
    '{33'h0, 1'b1, 110, 2},
    '{33'h11B, 1'b0, 80, 2}
  };

  gf2n_multiply_and_inverse_unit #(
    .MAX_DEGREE(32)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int poly_degree(input logic [63:0] p);
    for (int i = 63; i >= 0; i--) begin
      if (p[i]) return i;
    end
    return -1;
  endfunction

  function automatic logic [63:0] clmul64(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] acc;
    acc = '0;
    for (int i = 0; i < 64; i++) begin
      if (y[i]) acc ^= x << i;
    end
    return acc;
  endfunction

  function automatic logic [63:0] poly_mod(input logic [63:0] x, input logic [63:0] m,
                                           output logic [63:0] q);
    int dm;
    dm = poly_degree(m);
    q = '0;
    if (dm < 0) return x;
    for (int s = 63 - dm; s >= 0; s--) begin
      if (x[s + dm]) begin
        q[s] = 1'b1;
        x ^= m << s;
      end
    end
    return x;
  endfunction

  // extended Euclid; returns the Bezout coefficient of a
  function automatic logic [63:0] gf_invert(input logic [63:0] a, input logic [63:0] f);
    logic [63:0] num, den, u, v, q, r, t;
    num = f;
    den = a;
    u = '0;
    v = 64'd1;
    for (int i = 0; i < 140 && den != 0; i++) begin
      r = poly_mod(num, den, q);
      t = u ^ clmul64(q, v);
      num = den;
      den = r;
      u = v;
      v = t;
    end
    return u;
  endfunction

  function automatic gmi_pkg::rsp_t gf_unit_predict(input gmi_pkg::req_t r);
    logic [63:0] f, a, b, q, acc;
    logic bad;
    gmi_pkg::rsp_t o;
    f = {31'b0, field_poly};
    a = {32'b0, r.operand_a};
    b = {32'b0, r.operand_b};
    bad = poly_degree(f) <= 0;
    acc = '0;
    if (!bad) begin
      case (r.func)
        gmi_pkg::FUNC_CLMUL: acc = clmul64(a, b);
        gmi_pkg::FUNC_RMUL: acc = poly_mod(clmul64(a, b), f, q);
        gmi_pkg::FUNC_INV: acc = gf_invert(a, f);
        default: acc = '0;
      endcase
    end
    o.result = acc[62:0];
    o.bad_modulus = bad;
    return o;
  endfunction

  function automatic logic [31:0] random_operand(input int n);
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0: v = '0;
      1: v = 32'd1;
      2: v = 32'd1 << $urandom_range(31);
      3: v = '1;
      4: ;
      default: if (n > 0 && n < 32) v &= (32'd1 << n) - 32'd1;
    endcase
    return v;
  endfunction

  task automatic offer_request(input gmi_pkg::req_t r, input gmi_pkg::rsp_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    accepted_reqs++;
    awaited.push_back(want);
  endtask

  task automatic apb_cycle(input bit wr, input logic [32:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= gmi_pkg::ADDR_MODULUS;
    pwdata <= {31'b0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (wr) begin
      field_poly = v;
    end else if (prdata !== {31'b0, field_poly}) begin
      if (mismatches < 10)
        $display("modulus readback: want %h, got %h", field_poly, prdata);
      mismatches++;
    end
  endtask

  task automatic reprogram(input logic [32:0] poly);
    @(negedge clk);
    req_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    apb_cycle(1'b1, poly);
    apb_cycle(1'b0, poly);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_left == 0 && ((hold_next == 0 && accepted_reqs >= 60) ||
                           (hold_next == 1 && accepted_reqs >= 900))) begin
      hold_left = HOLD_CYCLES;
      hold_next++;
    end
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
    end
  end

  always @(posedge clk) begin
    gmi_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited.size() == 0) begin
        if (mismatches < 10) $display("unexpected response: result %h bad %b",
                                      rsp.result, rsp.bad_modulus);
        mismatches++;
      end else begin
        want = awaited.pop_front();
        if (rsp.result !== want.result || rsp.bad_modulus !== want.bad_modulus) begin
          if (mismatches < 10)
            $display("mismatch: want result %h bad %b, got result %h bad %b",
                     want.result, want.bad_modulus, rsp.result, rsp.bad_modulus);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    gmi_pkg::req_t r;
    gmi_pkg::rsp_t want;
    logic [63:0] m64;
    logic [32:0] poly;
    int d;
    int n;
    int k;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apb_cycle(1'b0, '0);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].poly != field_poly) reprogram(directed_rows[i].poly);
      r.func = directed_rows[i].func;
      r.operand_a = directed_rows[i].a;
      r.operand_b = directed_rows[i].b;
      if (directed_rows[i].typed) begin
        want.result = directed_rows[i].res;
        want.bad_modulus = directed_rows[i].bad;
      end else begin
        want = gf_unit_predict(r);
      end
      offer_request(r, want);
    end

    foreach (phases[p]) begin
      send_idle_pct = (phases[p].mode == 0) ? 22 : (phases[p].mode == 1) ? 64 : 0;
      rsp_idle_pct = (phases[p].mode == 0) ? 64 : (phases[p].mode == 1) ? 22 : 0;
      poly = phases[p].poly;
      if (phases[p].rnd) begin
        d = $urandom_range(32, 2);
        m64 = {$urandom, $urandom} & ((64'd1 << d) - 64'd1);
        m64[d] = 1'b1;
        poly = m64[32:0];
      end
      reprogram(poly);
      n = poly_degree({31'b0, field_poly});
      for (int i = 0; i < phases[p].count; i++) begin
        k = $urandom_range(19);
        r.func = (k == 0) ? FUNC_UNUSED : func_codes[k % 3];
        r.operand_a = random_operand(n);
        r.operand_b = random_operand(n);
        offer_request(r, gf_unit_predict(r));
      end
    end

    @(negedge clk);
    req_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
